### rtl/core/task_mailbox_ring_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Mailbox ring engine: assertion macros
// Shared concurrent check macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef TASK_MAILBOX_RING_ENGINE_CORE_DEFINES_SVH
`define TASK_MAILBOX_RING_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define TMR_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("mailbox engine check failed");

// next-cycle implication
`define TMR_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("mailbox engine check failed");

`endif

### rtl/core/tmr_pkg.sv
// ----------------------------------------------------------------------------
// Mailbox ring engine package
// Sizes, opcode and status codes, FSM states and control structs.
// ----------------------------------------------------------------------------
package tmr_pkg;

  localparam int BOXES      = 4;
  localparam int RING_DEPTH = 256;
  localparam int MAX_READ   = 64;

  localparam int BOX_W  = (BOXES > 1) ? $clog2(BOXES) : 1;
  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W = $clog2(BOXES * RING_DEPTH);

  // item field widths
  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int LEN_W  = 9;
  localparam int DATA_W = 8;
  localparam int RD_W   = 7;
  localparam int ST_W   = 2;

  // width for count/length/capacity compares
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER  = 2'd0,
    OP_SEND_HDR  = 2'd1,
    OP_SEND_BYTE = 2'd2,
    OP_RECEIVE   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOBOX    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CAPT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic rd_issue;
    logic rd_capture;
  } cmd_t;

  typedef struct packed {
    logic recv_go;
    logic out_last;
  } stat_t;

endpackage

### rtl/core/tmr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tmr_ctrl.sv
// ----------------------------------------------------------------------------
// Mailbox ring engine controller
// Sequences accept, execute, per-byte ring reads and result delivery.
// ----------------------------------------------------------------------------
`include "task_mailbox_ring_engine_core_defines.svh"

module tmr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tmr_pkg::stat_t stat,
  output tmr_pkg::cmd_t  cmd
);

  tmr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      tmr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = tmr_pkg::S_EXEC;
        end
      end
      tmr_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.recv_go ? tmr_pkg::S_READ : tmr_pkg::S_OUT;
      end
      tmr_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = tmr_pkg::S_CAPT;
      end
      tmr_pkg::S_CAPT: begin
        cmd.rd_capture = 1'b1;
        state_next     = tmr_pkg::S_OUT;
      end
      tmr_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = stat.out_last ? tmr_pkg::S_IDLE : tmr_pkg::S_READ;
        end
      end
      default: begin
        state_next = tmr_pkg::S_IDLE;
      end
    endcase
  end

  `TMR_ASSERT_NEXT(a_accept_then_exec, clk, rst, in_valid && in_ready, cmd.exec)
  `TMR_ASSERT_NEXT(a_issue_then_capture, clk, rst, cmd.rd_issue, cmd.rd_capture)
  `TMR_ASSERT_NEXT(a_more_bytes_read, clk, rst, out_valid && out_ready && !stat.out_last, cmd.rd_issue)

endmodule

### rtl/core/tmr_dp.sv
// ----------------------------------------------------------------------------
// Mailbox ring engine datapath
// Mailbox table, open-message state, ring memory and result register.
// ----------------------------------------------------------------------------
`include "task_mailbox_ring_engine_core_defines.svh"

module tmr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  tmr_pkg::cmd_t                cmd,
  output tmr_pkg::stat_t               stat,
  input  logic [tmr_pkg::OP_W-1:0]     opcode,
  input  logic [tmr_pkg::ID_W-1:0]     task_id,
  input  logic [tmr_pkg::LEN_W-1:0]    ring_capacity,
  input  logic [tmr_pkg::LEN_W-1:0]    msg_length,
  input  logic [tmr_pkg::DATA_W-1:0]   data_byte,
  input  logic [tmr_pkg::RD_W-1:0]     max_read,
  output tmr_pkg::status_t             status,
  output logic [tmr_pkg::DATA_W-1:0]   out_byte,
  output logic [tmr_pkg::RD_W-1:0]     byte_count,
  output logic                         last
);

  localparam int BOXES  = tmr_pkg::BOXES;
  localparam int BOX_W  = tmr_pkg::BOX_W;
  localparam int PTR_W  = tmr_pkg::PTR_W;
  localparam int CNT_W  = tmr_pkg::CNT_W;
  localparam int CMP_W  = tmr_pkg::CMP_W;
  localparam int ADDR_W = tmr_pkg::ADDR_W;
  localparam int RD_W   = tmr_pkg::RD_W;

  // latched item
  tmr_pkg::op_t                  op_q;
  logic [tmr_pkg::ID_W-1:0]      tid_q;
  logic [tmr_pkg::LEN_W-1:0]     cap_q;
  logic [tmr_pkg::LEN_W-1:0]     len_q;
  logic [tmr_pkg::DATA_W-1:0]    data_q;
  logic [RD_W-1:0]               want_q;

  // mailbox table
  logic [tmr_pkg::ID_W-1:0] owner [BOXES];
  logic [CNT_W-1:0]         box_cap [BOXES];
  logic [PTR_W-1:0]         wp [BOXES];
  logic [PTR_W-1:0]         rp [BOXES];
  logic [CNT_W-1:0]         cnt [BOXES];
  logic [BOX_W-1:0]         active_box;
  logic [tmr_pkg::LEN_W-1:0] bytes_left;

  // receive progress
  logic [BOX_W-1:0] rbox;
  logic [RD_W-1:0]  n_q;
  logic [RD_W-1:0]  k_q;

  // lookup
  logic             find_ok, find_done, free_ok;
  logic [BOX_W-1:0] find_idx, free_idx;
  logic [CNT_W-1:0] cap_eff;
  logic [CMP_W-1:0] cap_wide;
  logic             overflow;
  logic [RD_W-1:0]  want_eff, n_eff;
  logic             wr_ok;
  logic [CNT_W-1:0] wp_inc, rp_inc;
  logic [PTR_W-1:0] wp_next, rp_next;
  tmr_pkg::status_t exec_status;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [tmr_pkg::DATA_W-1:0] ram_rdata;

  always_comb begin
    find_ok   = 1'b0;
    find_done = 1'b0;
    find_idx  = '0;
    free_ok   = 1'b0;
    free_idx  = '0;
    // slot-order search: stop at first free slot or first owner match
    for (int b = 0; b < BOXES; b++) begin
      if (!find_done) begin
        if (owner[b] == '0) begin
          find_done = 1'b1;
        end else if (owner[b] == tid_q) begin
          find_ok   = 1'b1;
          find_idx  = BOX_W'(b);
          find_done = 1'b1;
        end
      end
    end
    for (int b = BOXES - 1; b >= 0; b--) begin
      if (owner[b] == '0) begin
        free_ok  = 1'b1;
        free_idx = BOX_W'(b);
      end
    end
  end

  always_comb begin
    cap_wide = CMP_W'(cap_q);
    if (cap_wide == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CMP_W'(tmr_pkg::RING_DEPTH)) begin
      cap_eff = CNT_W'(tmr_pkg::RING_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end

    overflow = (CMP_W'(cnt[find_idx]) + CMP_W'(len_q)) > CMP_W'(box_cap[find_idx]);

    if (want_q == '0) begin
      want_eff = RD_W'(1);
    end else if (want_q > RD_W'(tmr_pkg::MAX_READ)) begin
      want_eff = RD_W'(tmr_pkg::MAX_READ);
    end else begin
      want_eff = want_q;
    end

    if (CMP_W'(cnt[find_idx]) < CMP_W'(want_eff)) begin
      n_eff = RD_W'(cnt[find_idx]);
    end else begin
      n_eff = want_eff;
    end

    wr_ok = (bytes_left != '0) && (owner[active_box] != '0) &&
            (cnt[active_box] < box_cap[active_box]);

    wp_inc  = CNT_W'(wp[active_box]) + CNT_W'(1);
    wp_next = (wp_inc >= box_cap[active_box]) ? '0 : PTR_W'(wp_inc);
    rp_inc  = CNT_W'(rp[rbox]) + CNT_W'(1);
    rp_next = (rp_inc >= box_cap[rbox]) ? '0 : PTR_W'(rp_inc);

    case (op_q)
      tmr_pkg::OP_REGISTER: begin
        exec_status = (tid_q == '0 || free_ok) ? tmr_pkg::ST_OK : tmr_pkg::ST_FULL;
      end
      tmr_pkg::OP_SEND_HDR: begin
        if (!find_ok) begin
          exec_status = tmr_pkg::ST_NOBOX;
        end else if (overflow) begin
          exec_status = tmr_pkg::ST_OVERFLOW;
        end else begin
          exec_status = tmr_pkg::ST_OK;
        end
      end
      tmr_pkg::OP_RECEIVE: begin
        exec_status = find_ok ? tmr_pkg::ST_OK : tmr_pkg::ST_NOBOX;
      end
      default: begin
        exec_status = tmr_pkg::ST_OK;
      end
    endcase
  end

  assign stat.recv_go  = (op_q == tmr_pkg::OP_RECEIVE) && find_ok && (n_eff != '0);
  assign stat.out_last = last;

  assign ram_we    = cmd.exec && (op_q == tmr_pkg::OP_SEND_BYTE) && wr_ok;
  assign ram_waddr = ADDR_W'(active_box) * ADDR_W'(tmr_pkg::RING_DEPTH) +
                     ADDR_W'(wp[active_box]);
  assign ram_raddr = ADDR_W'(rbox) * ADDR_W'(tmr_pkg::RING_DEPTH) + ADDR_W'(rp[rbox]);

  tmr_ram #(
    .WIDTH (tmr_pkg::DATA_W),
    .DEPTH (BOXES * tmr_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // mailbox table and open message
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BOXES; b++) begin
        owner[b]   <= '0;
        box_cap[b] <= '0;
        wp[b]      <= '0;
        rp[b]      <= '0;
        cnt[b]     <= '0;
      end
      active_box <= '0;
      bytes_left <= '0;
    end else begin
      if (cmd.exec) begin
        case (op_q)
          tmr_pkg::OP_REGISTER: begin
            if (tid_q != '0 && free_ok) begin
              owner[free_idx]   <= tid_q;
              box_cap[free_idx] <= cap_eff;
              wp[free_idx]      <= '0;
              rp[free_idx]      <= '0;
              cnt[free_idx]     <= '0;
            end
          end
          tmr_pkg::OP_SEND_HDR: begin
            if (!find_ok || overflow) begin
              bytes_left <= '0;
            end else begin
              active_box <= find_idx;
              bytes_left <= len_q;
            end
          end
          tmr_pkg::OP_SEND_BYTE: begin
            if (wr_ok) begin
              wp[active_box]  <= wp_next;
              cnt[active_box] <= cnt[active_box] + CNT_W'(1);
              bytes_left      <= bytes_left - tmr_pkg::LEN_W'(1);
            end else begin
              bytes_left <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.rd_issue) begin
        rp[rbox]  <= rp_next;
        cnt[rbox] <= cnt[rbox] - CNT_W'(1);
      end
    end
  end

  // item latch, receive progress, result register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= tmr_pkg::op_t'(opcode);
      tid_q  <= task_id;
      cap_q  <= ring_capacity;
      len_q  <= msg_length;
      data_q <= data_byte;
      want_q <= max_read;
    end
    if (cmd.exec) begin
      rbox       <= find_idx;
      n_q        <= n_eff;
      k_q        <= '0;
      status     <= exec_status;
      out_byte   <= '0;
      byte_count <= '0;
      last       <= 1'b1;
    end
    if (cmd.rd_issue) begin
      k_q <= k_q + RD_W'(1);
    end
    if (cmd.rd_capture) begin
      status     <= tmr_pkg::ST_OK;
      out_byte   <= ram_rdata;
      byte_count <= k_q;
      last       <= (k_q == n_q);
    end
  end

  generate
    for (genvar g = 0; g < BOXES; g++) begin : g_chk
      `TMR_ASSERT_NOW(a_count_in_capacity, clk, rst, 1'b1, cnt[g] <= box_cap[g])
    end
  endgenerate
  `TMR_ASSERT_NOW(a_open_msg_owned, clk, rst, bytes_left != '0, owner[active_box] != '0)
  `TMR_ASSERT_NOW(a_read_within_count, clk, rst, cmd.rd_issue, k_q < n_q)

endmodule

### rtl/core/task_mailbox_ring_engine_core.sv
// Mailbox ring engine.
// Input stream s_axis: one word per operation (register box, send header,
// send byte, receive), opcode in tuser, operands in tdata.
// Output stream m_axis: result words; status in tuser, tlast on the final
// word of each operation. A receive that reads n > 0 bytes gives n words;
// every other operation, and a receive that reads none, gives exactly one word.
// Timing: a word is executed in the cycle after it is taken; a single-result
// operation then shows its word in S_OUT. A receive reads the ring memory one
// byte at a time through its registered read port, passing S_READ, S_CAPT
// and S_OUT for each byte.
// One operation is in flight at a time; s_axis_tready is high only while idle.
// Stall: when m_axis_tready is low the result word holds and nothing else
// advances.
// Reset: rst (synchronous) frees all mailboxes and closes any open message;
// ring memory contents are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
// Mailbox ring engine top level
// Stream wrapper joining the controller and the datapath.
// ----------------------------------------------------------------------------
module task_mailbox_ring_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] task_id, [16:8] ring_capacity, [25:17] msg_length,
  // [33:26] data_byte, [40:34] max_read, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [14:8] byte_count, [15] zero
  output logic [15:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  tmr_pkg::cmd_t    cmd;
  tmr_pkg::stat_t   stat;
  tmr_pkg::status_t status;
  logic [tmr_pkg::DATA_W-1:0] out_byte;
  logic [tmr_pkg::RD_W-1:0]   byte_count;

  tmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (s_axis_tuser),
    .task_id       (s_axis_tdata[7:0]),
    .ring_capacity (s_axis_tdata[16:8]),
    .msg_length    (s_axis_tdata[25:17]),
    .data_byte     (s_axis_tdata[33:26]),
    .max_read      (s_axis_tdata[40:34]),
    .status        (status),
    .out_byte      (out_byte),
    .byte_count    (byte_count),
    .last          (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, byte_count, out_byte};
  assign m_axis_tuser = status;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Mailbox ring engine testbench
// Streams register, send header, send byte and receive operations into the
// core while both stream sides take random pauses. A local mailbox table
// predicts every result word, and the monitor checks each word field by field
// in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tmr_pkg::op_t                      op;
    logic [tmr_pkg::ID_W-1:0]          tid;
    logic [tmr_pkg::LEN_W-1:0]         cap;
    logic [tmr_pkg::LEN_W-1:0]         len;
    logic [tmr_pkg::DATA_W-1:0]        data;
    logic [tmr_pkg::RD_W-1:0]          rd_max;
    bit                                hold;   // wait for all results before sending
  } mbox_op_t;

  typedef struct {
    tmr_pkg::status_t                  status;
    logic [tmr_pkg::DATA_W-1:0]        rbyte;
    logic [tmr_pkg::RD_W-1:0]          count;
    logic                              last;
  } mbox_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  mbox_op_t   op_queue[$];
  mbox_word_t pending_results[$];
  mbox_op_t   in_flight;
  int         mismatches = 0;
  int         accepted_ops = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  logic       calm;

  // mailbox table as the core should hold it
  logic [tmr_pkg::ID_W-1:0]   box_owner  [tmr_pkg::BOXES];
  logic [tmr_pkg::LEN_W-1:0]  box_size   [tmr_pkg::BOXES];
  logic [tmr_pkg::PTR_W-1:0]  box_wr     [tmr_pkg::BOXES];
  logic [tmr_pkg::PTR_W-1:0]  box_rd     [tmr_pkg::BOXES];
  logic [tmr_pkg::CNT_W-1:0]  box_unread [tmr_pkg::BOXES];
  logic [tmr_pkg::DATA_W-1:0] box_ring   [tmr_pkg::BOXES][tmr_pkg::RING_DEPTH];
  logic [tmr_pkg::BOX_W-1:0]  open_box;
  logic [tmr_pkg::LEN_W-1:0]  open_left;

  // no pauses on either side over a stretch of the run
  assign calm = (accepted_ops >= 120) && (accepted_ops < 170);

  always #5 clk = ~clk;

  task_mailbox_ring_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_word(tmr_pkg::status_t st, logic [tmr_pkg::DATA_W-1:0] v,
                                    logic [tmr_pkg::RD_W-1:0] c, logic l);
    mbox_word_t w;
    w.status = st;
    w.rbyte  = v;
    w.count  = c;
    w.last   = l;
    pending_results.push_back(w);
  endfunction

  // lookup stops at the first free slot; lowest matching slot wins
  function automatic int find_owner(logic [tmr_pkg::ID_W-1:0] id);
    for (int b = 0; b < tmr_pkg::BOXES; b++) begin
      if (box_owner[b] == 0) return tmr_pkg::BOXES;
      if (box_owner[b] == id) return b;
    end
    return tmr_pkg::BOXES;
  endfunction

  task automatic run_mailbox_op(input mbox_op_t it);
    int b;
    int n;
    int want;
    int nxt;
    b = tmr_pkg::BOXES;
    case (it.op)
      tmr_pkg::OP_REGISTER: begin
        if (it.tid == 0) begin
          push_word(tmr_pkg::ST_OK, '0, '0, 1'b1);
        end else begin
          for (int s = tmr_pkg::BOXES - 1; s >= 0; s--)
            if (box_owner[s] == 0) b = s;
          if (b == tmr_pkg::BOXES) begin
            push_word(tmr_pkg::ST_FULL, '0, '0, 1'b1);
          end else begin
            box_owner[b]  = it.tid;
            if (it.cap == 0)
              box_size[b] = tmr_pkg::LEN_W'(1);
            else if (it.cap > tmr_pkg::RING_DEPTH)
              box_size[b] = tmr_pkg::LEN_W'(tmr_pkg::RING_DEPTH);
            else
              box_size[b] = it.cap;
            box_wr[b]     = '0;
            box_rd[b]     = '0;
            box_unread[b] = '0;
            push_word(tmr_pkg::ST_OK, '0, '0, 1'b1);
          end
        end
      end
      tmr_pkg::OP_SEND_HDR: begin
        b = find_owner(it.tid);
        if (b == tmr_pkg::BOXES) begin
          open_left = '0;
          push_word(tmr_pkg::ST_NOBOX, '0, '0, 1'b1);
        end else if (int'(box_unread[b]) + int'(it.len) > int'(box_size[b])) begin
          open_left = '0;
          push_word(tmr_pkg::ST_OVERFLOW, '0, '0, 1'b1);
        end else begin
          open_box  = tmr_pkg::BOX_W'(b);
          open_left = it.len;
          push_word(tmr_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      tmr_pkg::OP_SEND_BYTE: begin
        if (open_left != 0 && box_owner[open_box] != 0 &&
            box_unread[open_box] < box_size[open_box]) begin
          box_ring[open_box][box_wr[open_box]] = it.data;
          nxt = int'(box_wr[open_box]) + 1;
          box_wr[open_box] = (nxt >= int'(box_size[open_box])) ? '0
                                                               : tmr_pkg::PTR_W'(nxt);
          box_unread[open_box] = box_unread[open_box] + tmr_pkg::CNT_W'(1);
          open_left = open_left - tmr_pkg::LEN_W'(1);
        end else begin
          open_left = '0;
        end
        push_word(tmr_pkg::ST_OK, '0, '0, 1'b1);
      end
      default: begin
        b = find_owner(it.tid);
        if (b == tmr_pkg::BOXES) begin
          push_word(tmr_pkg::ST_NOBOX, '0, '0, 1'b1);
        end else begin
          want = (it.rd_max == 0) ? 1 :
                 (it.rd_max > tmr_pkg::MAX_READ) ? tmr_pkg::MAX_READ : int'(it.rd_max);
          n = (int'(box_unread[b]) < want) ? int'(box_unread[b]) : want;
          if (n == 0) push_word(tmr_pkg::ST_OK, '0, '0, 1'b1);
          for (int k = 0; k < n; k++) begin
            push_word(tmr_pkg::ST_OK, box_ring[b][box_rd[b]], tmr_pkg::RD_W'(k + 1),
                      (k + 1) == n);
            nxt = int'(box_rd[b]) + 1;
            box_rd[b] = (nxt >= int'(box_size[b])) ? '0 : tmr_pkg::PTR_W'(nxt);
            box_unread[b] = box_unread[b] - tmr_pkg::CNT_W'(1);
          end
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // queue one operation; arg lands in the field that the opcode uses,
  // every other field carries random junk the core must ignore
  function automatic void add_op(tmr_pkg::op_t op, int tid, int arg, bit hold = 1'b0);
    mbox_op_t it;
    it.op     = op;
    it.tid    = tmr_pkg::ID_W'($urandom);
    it.cap    = tmr_pkg::LEN_W'($urandom);
    it.len    = tmr_pkg::LEN_W'($urandom);
    it.data   = tmr_pkg::DATA_W'($urandom);
    it.rd_max = tmr_pkg::RD_W'($urandom);
    it.hold   = hold;
    if (op != tmr_pkg::OP_SEND_BYTE) it.tid = tmr_pkg::ID_W'(tid);
    case (op)
      tmr_pkg::OP_REGISTER:  it.cap    = tmr_pkg::LEN_W'(arg);
      tmr_pkg::OP_SEND_HDR:  it.len    = tmr_pkg::LEN_W'(arg);
      tmr_pkg::OP_SEND_BYTE: it.data   = tmr_pkg::DATA_W'(arg);
      default:               it.rd_max = tmr_pkg::RD_W'(arg);
    endcase
    op_queue.push_back(it);
  endfunction

  // driver
  always @(posedge clk) begin : driver
    logic     busy;
    mbox_op_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        run_mailbox_op(in_flight);
        accepted_ops <= accepted_ops + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (op_queue.size() != 0 &&
                     !(op_queue[0].hold && pending_results.size() != 0)) begin
          it = op_queue.pop_front();
          in_flight     <= it;
          s_axis_tdata  <= {7'b0, it.rd_max, it.data, it.len, it.cap, it.tid};
          s_axis_tuser  <= it.op;
          s_axis_tvalid <= 1'b1;
          gap_left      <= calm ? 0 : pick_pause();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    mbox_word_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result word with nothing pending", m_axis_tdata, '0);
        end else begin
          w = pending_results.pop_front();
          if (m_axis_tuser !== w.status)
            flag_mismatch("status", 16'(m_axis_tuser), 16'(w.status));
          if (m_axis_tdata[7:0] !== w.rbyte)
            flag_mismatch("out_byte", 16'(m_axis_tdata[7:0]), 16'(w.rbyte));
          if (m_axis_tdata[14:8] !== w.count)
            flag_mismatch("byte_count", 16'(m_axis_tdata[14:8]), 16'(w.count));
          if (m_axis_tlast !== w.last)
            flag_mismatch("last", 16'(m_axis_tlast), 16'(w.last));
        end
      end
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) < 3) stall_left <= pick_pause();
      end
    end
  end

  initial begin : stimulus
    int                        made;
    int                        r;
    int                        k;
    int                        len;
    int                        nb;
    logic [tmr_pkg::ID_W-1:0]  id;
    logic [tmr_pkg::ID_W-1:0]  known [3];
    bit                        hold;
    known[0] = 8'h01;
    known[1] = 8'hFF;
    known[2] = 8'h80;
    for (int b = 0; b < tmr_pkg::BOXES; b++) begin
      box_owner[b]  = '0;
      box_size[b]   = '0;
      box_wr[b]     = '0;
      box_rd[b]     = '0;
      box_unread[b] = '0;
    end
    open_box  = '0;
    open_left = '0;

    add_op(tmr_pkg::OP_RECEIVE, 8'h01, 0);        // empty table, read size zero
    add_op(tmr_pkg::OP_SEND_BYTE, 0, 8'hAA);      // no message open
    add_op(tmr_pkg::OP_REGISTER, 8'h00, 100);     // task id zero changes nothing
    add_op(tmr_pkg::OP_REGISTER, 8'h01, 0);       // capacity zero counts as one
    add_op(tmr_pkg::OP_REGISTER, 8'hFF, 511);     // capacity clipped to ring depth
    add_op(tmr_pkg::OP_SEND_HDR, 8'h42, 0);       // free slot ends lookup
    add_op(tmr_pkg::OP_REGISTER, 8'h80, 7);
    add_op(tmr_pkg::OP_REGISTER, 8'h01, 300);     // duplicate owner, unreachable
    add_op(tmr_pkg::OP_REGISTER, 8'h33, 1);       // table full
    add_op(tmr_pkg::OP_SEND_HDR, 8'h01, 511);     // overflow closes message
    add_op(tmr_pkg::OP_SEND_HDR, 8'h01, 1);
    add_op(tmr_pkg::OP_SEND_BYTE, 0, 8'h00);
    add_op(tmr_pkg::OP_SEND_BYTE, 0, 8'hFF);      // past declared length
    add_op(tmr_pkg::OP_SEND_HDR, 8'hFF, 256);
    add_op(tmr_pkg::OP_SEND_BYTE, 0, 8'hC3);
    add_op(tmr_pkg::OP_SEND_HDR, 8'h80, 7);       // drops rest of open message
    for (k = 0; k < 7; k++) add_op(tmr_pkg::OP_SEND_BYTE, 0, 8'h11 * (k + 1));
    add_op(tmr_pkg::OP_SEND_HDR, 8'h80, 0);       // full ring, zero length fits
    add_op(tmr_pkg::OP_RECEIVE, 8'h80, 127);      // read size clipped
    add_op(tmr_pkg::OP_RECEIVE, 8'h01, 1);
    add_op(tmr_pkg::OP_RECEIVE, 8'hFF, 64);
    add_op(tmr_pkg::OP_RECEIVE, 8'hFF, 5);        // empty box

    made = 0;
    while (made < 280) begin
      r    = $urandom_range(0, 99);
      hold = (made == 0) || ($urandom_range(0, 39) == 0);
      if (r < 55) begin
        id = ($urandom_range(0, 19) == 0) ? 8'($urandom) : known[$urandom_range(0, 2)];
        if (id == 8'h01)      len = $urandom_range(0, 1);
        else if (id == 8'h80) len = $urandom_range(0, 7);
        else                  len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12)
                                                               : $urandom_range(13, 60);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 511);
        nb = len;
        r  = $urandom_range(0, 9);
        if (r == 0) nb = len + $urandom_range(1, 3);
        else if (r == 1 && len > 0) nb = $urandom_range(0, len - 1);
        if (nb > 70) nb = 70;
        add_op(tmr_pkg::OP_SEND_HDR, id, len, hold);
        for (k = 0; k < nb; k++) add_op(tmr_pkg::OP_SEND_BYTE, 0, $urandom_range(0, 255));
        made += 1 + nb;
      end else if (r < 85) begin
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : known[$urandom_range(0, 2)];
        r  = $urandom_range(0, 9);
        add_op(tmr_pkg::OP_RECEIVE, id, (r < 8) ? $urandom_range(1, 64) :
                                        (r == 8) ? 0 : $urandom_range(65, 127), hold);
        made++;
      end else begin
        add_op(tmr_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
               $urandom_range(0, 511), hold);
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (op_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule
